// ===== src/vsrd_pkg.sv =====
package vsrd_pkg;

  localparam logic [7:0] END_FLAG   = 8'h7F;
  localparam logic [7:0] VALUE_FLAG = 8'h80;
  localparam logic [7:0] PHASE_FLAG = 8'h81;
  localparam logic [7:0] ERROR_FLAG = 8'hE0;
  localparam logic [7:0] HDR_BREATH   = 8'h42;  // 'B'
  localparam logic [7:0] HDR_SETTINGS = 8'h53;  // 'S'
  localparam logic [7:0] HDR_TREND    = 8'h54;  // 'T'
  localparam logic [7:0] HDR_ALARM    = 8'h41;  // 'A'

  localparam logic [2:0] KIND_BREATH_WORD   = 3'd0;
  localparam logic [2:0] KIND_SETTINGS_WORD = 3'd1;
  localparam logic [2:0] KIND_BREATH_END    = 3'd2;
  localparam logic [2:0] KIND_SETTINGS_END  = 3'd3;
  localparam logic [2:0] KIND_CURVE         = 3'd4;
  localparam logic [2:0] KIND_PHASE         = 3'd5;
  localparam logic [2:0] KIND_ERROR         = 3'd6;

  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] REG_CURVE_COUNT = 3'd0;
  localparam logic [1:0] CURVE_COUNT_RESET = 2'd3;

endpackage

// ===== src/vsrd_if.sv =====
interface vsrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface vsrd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  index;
  logic [15:0] value;
  logic        overflow;

  modport source (output valid, output kind, output index, output value, output overflow,
                  input ready);
  modport sink (input valid, input kind, input index, input value, input overflow,
                output ready);
endinterface

// ===== src/ventilator_serial_record_deframer_top.sv =====
// Channel  | Dir | Payload                             | Handshake
// rx_i     | in  | rx_byte[7:0]                        | valid/ready
// res_o    | out | kind[2:0] index[3:0] value[15:0] ovf | valid/ready
// cfg      | in  | APB, curve_count at 0x0             | psel/penable, pready=1
//
// One byte per cycle while rx_i.ready is high; a result shows on res_o
// the cycle after its byte is taken, held in the single result register.
// rst_ni clears parser state, curve accumulators and curve_count (to 3).
// rx_i.ready is high whenever the result register is empty or being read.
// A stalled result holds rx_i until res_o.ready returns.
module ventilator_serial_record_deframer_top
  import vsrd_pkg::*;
#(
  parameter int unsigned WORD_SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  vsrd_in_if.sink            rx_i,
  vsrd_out_if.source         res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned SLOT_W = $clog2(WORD_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WORD_SLOTS - 1);

  typedef enum logic [3:0] {
    M_AWAIT, M_ENDFOUND, M_BREATH, M_SETTINGS, M_SKIP, M_ERROR, M_VALUE, M_PHASE, M_RUN
  } mode_e;

  mode_e             mode_q, mode_d;
  logic [1:0]        bytes_left_q, bytes_left_d;
  logic [SLOT_W-1:0] word_slot_q, word_slot_d;
  logic [7:0]        high_byte_q, high_byte_d;
  logic [1:0]        curve_sel_q, curve_sel_d;
  logic [15:0]       accum_q [3];
  logic [15:0]       accum_d [3];
  logic              ovf_seen_q, ovf_seen_d;
  logic [1:0]        curve_count_q;

  logic              out_valid_q, out_valid_d;
  logic [2:0]        kind_q, kind_d;
  logic [3:0]        index_q, index_d;
  logic [15:0]       value_q, value_d;
  logic              ovf_q, ovf_d;

  logic        accept;
  logic        emit;
  logic [7:0]  b;
  logic [1:0]  sel;
  logic [1:0]  sel_next;
  logic [15:0] slot_ext;
  logic [2:0]  word_kind;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_CURVE_COUNT);
  assign prdata = (paddr == REG_CURVE_COUNT) ? {30'd0, curve_count_q} : 32'd0;

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;

  assign res_o.valid    = out_valid_q;
  assign res_o.kind     = kind_q;
  assign res_o.index    = index_q;
  assign res_o.value    = value_q;
  assign res_o.overflow = ovf_q;

  assign sel       = (curve_sel_q == 2'd3) ? 2'd0 : curve_sel_q;
  assign slot_ext  = 16'(word_slot_q);
  assign word_kind = (mode_q == M_BREATH) ? KIND_BREATH_WORD : KIND_SETTINGS_WORD;

  always_comb begin
    case (sel)
      2'd0:    sel_next = (curve_count_q > 2'd1) ? 2'd1 : 2'd0;
      2'd1:    sel_next = (curve_count_q > 2'd2) ? 2'd2 : 2'd0;
      default: sel_next = 2'd0;
    endcase
  end

  always_comb begin
    mode_d       = mode_q;
    bytes_left_d = bytes_left_q;
    word_slot_d  = word_slot_q;
    high_byte_d  = high_byte_q;
    curve_sel_d  = curve_sel_q;
    accum_d      = accum_q;
    ovf_seen_d   = ovf_seen_q;
    emit         = 1'b0;
    kind_d       = kind_q;
    index_d      = index_q;
    value_d      = value_q;
    ovf_d        = ovf_q;
    if (accept) begin
      unique case (mode_q)
        M_AWAIT: begin
          if (b == HDR_BREATH || b == HDR_SETTINGS) begin
            mode_d       = (b == HDR_BREATH) ? M_BREATH : M_SETTINGS;
            word_slot_d  = '0;
            bytes_left_d = 2'd2;
            ovf_seen_d   = 1'b0;
          end else if (b == HDR_TREND || b == HDR_ALARM) begin
            mode_d = M_SKIP;
          end else if (b == ERROR_FLAG) begin
            mode_d       = M_ERROR;
            bytes_left_d = 2'd1;
          end else if (b == VALUE_FLAG) begin
            mode_d       = M_VALUE;
            bytes_left_d = 2'd2;
          end else if (b == PHASE_FLAG) begin
            mode_d       = M_PHASE;
            bytes_left_d = 2'd1;
          end
        end
        M_ENDFOUND: mode_d = M_AWAIT;
        M_BREATH, M_SETTINGS: begin
          if (bytes_left_q == 2'd2) begin
            high_byte_d  = b;
            bytes_left_d = 2'd1;
          end else if (bytes_left_q == 2'd1) begin
            bytes_left_d = 2'd0;
            emit    = 1'b1;
            kind_d  = word_kind;
            index_d = slot_ext[3:0];
            value_d = {high_byte_q, b};
            ovf_d   = ovf_seen_q;
          end else if (b == END_FLAG) begin
            mode_d  = M_ENDFOUND;
            emit    = 1'b1;
            kind_d  = word_kind + 3'd2;
            index_d = 4'd0;
            value_d = slot_ext + 16'd1;
            ovf_d   = ovf_seen_q;
          end else begin
            if (word_slot_q != LAST_SLOT) begin
              word_slot_d = word_slot_q + SLOT_W'(1);
            end else begin
              ovf_seen_d = 1'b1;
            end
            high_byte_d  = b;
            bytes_left_d = 2'd1;
          end
        end
        M_SKIP: begin
          if (b == END_FLAG) mode_d = M_ENDFOUND;
        end
        M_ERROR: begin
          if (b == END_FLAG) begin
            mode_d = M_ENDFOUND;
          end else begin
            emit    = 1'b1;
            kind_d  = KIND_ERROR;
            index_d = 4'd0;
            value_d = {8'd0, b};
            ovf_d   = 1'b0;
          end
        end
        M_VALUE: begin
          if (bytes_left_q != 2'd1) begin
            high_byte_d  = b;
            bytes_left_d = 2'd1;
          end else begin
            accum_d[sel] = {high_byte_q, b};
            bytes_left_d = 2'd0;
            mode_d       = M_RUN;
            emit         = 1'b1;
            kind_d       = KIND_CURVE;
            index_d      = {2'd0, sel};
            value_d      = {high_byte_q, b};
            ovf_d        = 1'b0;
            curve_sel_d  = sel_next;
          end
        end
        M_PHASE: begin
          bytes_left_d = 2'd0;
          mode_d       = M_RUN;
          emit         = 1'b1;
          kind_d       = KIND_PHASE;
          index_d      = 4'd0;
          value_d      = {8'd0, b};
          ovf_d        = 1'b0;
        end
        M_RUN: begin
          if (b == VALUE_FLAG) begin
            mode_d       = M_VALUE;
            bytes_left_d = 2'd2;
          end else if (b == PHASE_FLAG) begin
            mode_d       = M_PHASE;
            bytes_left_d = 2'd1;
          end else if (b == END_FLAG) begin
            mode_d = M_ENDFOUND;
          end else begin
            accum_d[sel] = accum_q[sel] + {{8{b[7]}}, b};
            emit         = 1'b1;
            kind_d       = KIND_CURVE;
            index_d      = {2'd0, sel};
            value_d      = accum_q[sel] + {{8{b[7]}}, b};
            ovf_d        = 1'b0;
            curve_sel_d  = sel_next;
          end
        end
        default: mode_d = M_AWAIT;
      endcase
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_d = emit;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= M_AWAIT;
      bytes_left_q  <= 2'd0;
      word_slot_q   <= '0;
      high_byte_q   <= 8'd0;
      curve_sel_q   <= 2'd0;
      accum_q[0]    <= 16'd0;
      accum_q[1]    <= 16'd0;
      accum_q[2]    <= 16'd0;
      ovf_seen_q    <= 1'b0;
      curve_count_q <= CURVE_COUNT_RESET;
      out_valid_q   <= 1'b0;
      kind_q        <= 3'd0;
      index_q       <= 4'd0;
      value_q       <= 16'd0;
      ovf_q         <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      bytes_left_q <= bytes_left_d;
      word_slot_q  <= word_slot_d;
      high_byte_q  <= high_byte_d;
      curve_sel_q  <= curve_sel_d;
      accum_q      <= accum_d;
      ovf_seen_q   <= ovf_seen_d;
      out_valid_q  <= out_valid_d;
      kind_q       <= kind_d;
      index_q      <= index_d;
      value_q      <= value_d;
      ovf_q        <= ovf_d;
      if (cfg_wr) curve_count_q <= pwdata[1:0];
    end
  end

  a_curve_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    curve_sel_q != 2'd3)
    else $error("curve select out of range");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_slot_q <= LAST_SLOT)
    else $error("word slot past last slot");

  a_ovf_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == KIND_CURVE || kind_q == KIND_PHASE || kind_q == KIND_ERROR))
      |-> !ovf_q)
    else $error("overflow on non-word result");

  a_curve_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_CURVE) |-> (index_q < 4'd3))
    else $error("curve index out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> (out_valid_q && $stable(value_q)))
    else $error("pending result lost");

endmodule

// ===== tb/ventilator_serial_record_deframer_top_tb.sv =====
`timescale 1ns / 100ps

module ventilator_serial_record_deframer_top_tb
  import vsrd_pkg::*;
;
  localparam int unsigned SLOT_COUNT = 16;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam logic [PADDR_W-1:0] UNUSED_REG_ADDR = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  index;
    logic [15:0] value;
    logic        overflow;
  } deframe_result_t;

  typedef enum logic [3:0] {
    PARSE_HEADER,
    PARSE_CHECKSUM,
    PARSE_BREATH,
    PARSE_SETTINGS,
    PARSE_SKIP,
    PARSE_ERROR,
    PARSE_VALUE,
    PARSE_PHASE,
    PARSE_RUN
  } parse_state_e;

  class deframe_scoreboard;
    logic [1:0]      curve_count = CURVE_COUNT_RESET;
    parse_state_e    state = PARSE_HEADER;
    logic [1:0]      bytes_left = 2'd0;
    logic [4:0]      word_slot = 5'd0;
    logic [7:0]      high_byte = 8'd0;
    logic [1:0]      curve_sel = 2'd0;
    logic [15:0]     curve_accum [3] = '{16'd0, 16'd0, 16'd0};
    logic            overflow_seen = 1'b0;
    deframe_result_t pending [$];

    function void expect_word(logic [2:0] kind, logic [3:0] index, logic [15:0] value,
                              logic ovf);
      pending.push_back({kind, index, value, ovf});
    endfunction

    function void next_curve();
      case (curve_sel)
        2'd0: curve_sel = (curve_count > 2'd1) ? 2'd1 : 2'd0;
        2'd1: curve_sel = (curve_count > 2'd2) ? 2'd2 : 2'd0;
        default: curve_sel = 2'd0;
      endcase
    endfunction

    function void record_byte(logic [7:0] b, logic [2:0] word_kind, logic [2:0] end_kind);
      if (bytes_left == 2'd2) begin
        high_byte = b;
        bytes_left = 2'd1;
      end else if (bytes_left == 2'd1) begin
        bytes_left = 2'd0;
        expect_word(word_kind, word_slot[3:0], {high_byte, b}, overflow_seen);
      end else if (b == END_FLAG) begin
        state = PARSE_CHECKSUM;
        expect_word(end_kind, 4'd0, 16'(word_slot) + 16'd1, overflow_seen);
      end else begin
        // past the last slot the word overwrites it
        if (32'(word_slot) + 1 < SLOT_COUNT) word_slot = word_slot + 5'd1;
        else overflow_seen = 1'b1;
        high_byte = b;
        bytes_left = 2'd1;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [1:0] sel;
      sel = (curve_sel > 2'd2) ? 2'd0 : curve_sel;
      case (state)
        PARSE_HEADER: begin
          if (b == HDR_BREATH || b == HDR_SETTINGS) begin
            state = (b == HDR_BREATH) ? PARSE_BREATH : PARSE_SETTINGS;
            word_slot = 5'd0;
            bytes_left = 2'd2;
            overflow_seen = 1'b0;
          end else if (b == HDR_TREND || b == HDR_ALARM) begin
            state = PARSE_SKIP;
          end else if (b == ERROR_FLAG) begin
            state = PARSE_ERROR;
            bytes_left = 2'd1;
          end else if (b == VALUE_FLAG) begin
            state = PARSE_VALUE;
            bytes_left = 2'd2;
          end else if (b == PHASE_FLAG) begin
            state = PARSE_PHASE;
            bytes_left = 2'd1;
          end
        end
        PARSE_CHECKSUM: state = PARSE_HEADER;
        PARSE_BREATH: record_byte(b, KIND_BREATH_WORD, KIND_BREATH_END);
        PARSE_SETTINGS: record_byte(b, KIND_SETTINGS_WORD, KIND_SETTINGS_END);
        PARSE_SKIP: begin
          if (b == END_FLAG) state = PARSE_CHECKSUM;
        end
        PARSE_ERROR: begin
          if (b == END_FLAG) state = PARSE_CHECKSUM;
          else expect_word(KIND_ERROR, 4'd0, {8'd0, b}, 1'b0);
        end
        PARSE_VALUE: begin
          if (bytes_left != 2'd1) begin
            high_byte = b;
            bytes_left = 2'd1;
          end else begin
            curve_accum[sel] = {high_byte, b};
            bytes_left = 2'd0;
            state = PARSE_RUN;
            expect_word(KIND_CURVE, {2'd0, sel}, curve_accum[sel], 1'b0);
            next_curve();
          end
        end
        PARSE_PHASE: begin
          bytes_left = 2'd0;
          state = PARSE_RUN;
          expect_word(KIND_PHASE, 4'd0, {8'd0, b}, 1'b0);
        end
        PARSE_RUN: begin
          if (b == VALUE_FLAG) begin
            state = PARSE_VALUE;
            bytes_left = 2'd2;
          end else if (b == PHASE_FLAG) begin
            state = PARSE_PHASE;
            bytes_left = 2'd1;
          end else if (b == END_FLAG) begin
            state = PARSE_CHECKSUM;
          end else begin
            curve_accum[sel] = curve_accum[sel] + {{8{b[7]}}, b};
            expect_word(KIND_CURVE, {2'd0, sel}, curve_accum[sel], 1'b0);
            next_curve();
          end
        end
        default: state = PARSE_HEADER;
      endcase
    endfunction

    function string check_result(deframe_result_t got);
      deframe_result_t want;
      string msg;
      if (pending.size() == 0)
        return $sformatf("word with none pending: kind=%0d index=%0d value=%h ovf=%0d",
                         got.kind, got.index, got.value, got.overflow);
      want = pending.pop_front();
      msg = "";
      if (got.kind != want.kind)
        msg = {msg, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
      if (got.index != want.index)
        msg = {msg, $sformatf(" index %0d/%0d", got.index, want.index)};
      if (got.value != want.value)
        msg = {msg, $sformatf(" value %h/%h", got.value, want.value)};
      if (got.overflow != want.overflow)
        msg = {msg, $sformatf(" ovf %0d/%0d", got.overflow, want.overflow)};
      if (msg.len() != 0) msg = {"result got/want:", msg};
      return msg;
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  vsrd_in_if  rx_if ();
  vsrd_out_if res_if ();

  deframe_scoreboard sb = new();

  int errors = 0;
  int sent = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_cycles = 0;
  bit hold_req = 1'b0;

  ventilator_serial_record_deframer_top #(
    .WORD_SLOTS(SLOT_COUNT)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic report(string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : monitor
    string msg;
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) sb.note_byte(rx_if.rx_byte);
      if (res_if.valid && res_if.ready) begin
        msg = sb.check_result({res_if.kind, res_if.index, res_if.value, res_if.overflow});
        if (msg.len() != 0) report(msg);
      end
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    sent++;
  endtask

  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == END_FLAG);
    return b;
  endfunction

  function automatic logic [7:0] delta_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == END_FLAG || b == VALUE_FLAG || b == PHASE_FLAG);
    return b;
  endfunction

  task automatic send_word_record(logic [7:0] hdr);
    int words;
    logic [7:0] hi;
    words = ($urandom_range(0, 7) == 0) ? $urandom_range(SLOT_COUNT - 1, SLOT_COUNT + 4)
                                        : $urandom_range(1, 5);
    send_byte(hdr);
    for (int w = 0; w < words; w++) begin
      hi = (w == 0) ? 8'($urandom) : payload_byte();
      send_byte(hi);
      send_byte(8'($urandom));
    end
    send_byte(END_FLAG);
    send_byte(8'($urandom));
  endtask

  task automatic send_flat_record(logic [7:0] hdr);
    int len;
    len = $urandom_range(0, 6);
    send_byte(hdr);
    repeat (len) send_byte(payload_byte());
    send_byte(END_FLAG);
    send_byte(8'($urandom));
  endtask

  task automatic send_value();
    send_byte(VALUE_FLAG);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
  endtask

  task automatic send_curve_run();
    int len;
    int pick;
    if ($urandom_range(0, 1) == 0) begin
      send_value();
    end else begin
      send_byte(PHASE_FLAG);
      send_byte(8'($urandom));
    end
    len = $urandom_range(1, 12);
    repeat (len) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_value();
      end else if (pick == 1) begin
        send_byte(PHASE_FLAG);
        send_byte(8'($urandom));
      end else begin
        send_byte(delta_byte());
      end
    end
    send_byte(END_FLAG);
    send_byte(8'($urandom));
  endtask

  task automatic random_traffic(int count);
    int stop_at;
    int pick;
    stop_at = sent + count;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) send_word_record(HDR_BREATH);
      else if (pick < 40) send_word_record(HDR_SETTINGS);
      else if (pick < 46) send_flat_record(HDR_TREND);
      else if (pick < 50) send_flat_record(HDR_ALARM);
      else if (pick < 58) send_flat_record(ERROR_FLAG);
      else if (pick < 90) send_curve_run();
      else send_byte(8'($urandom));
    end
  endtask

  task automatic wait_idle();
    rx_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_curve_count(logic [1:0] n);
    logic [31:0] rd;
    wait_idle();
    apb_access(1'b1, REG_CURVE_COUNT, {30'd0, n}, rd);
    sb.curve_count = n;
    apb_access(1'b1, UNUSED_REG_ADDR, $urandom, rd);
    apb_access(1'b0, REG_CURVE_COUNT, 32'd0, rd);
    if (rd != {30'd0, n}) report($sformatf("curve_count read %h, want %0d", rd, n));
  endtask

  initial begin : stimulus
    logic [31:0] rd;
    logic [7:0]  directed [$];
    rst_ni        <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'd0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= 32'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_access(1'b0, REG_CURVE_COUNT, 32'd0, rd);
    if (rd != {30'd0, CURVE_COUNT_RESET}) report($sformatf("curve_count after reset %h", rd));

    // word 0 may hold end flags; stray end flag between records is ignored
    directed = '{HDR_BREATH, 8'h00, 8'h00, 8'hFF, 8'hFF, END_FLAG, 8'hFF,
                 HDR_SETTINGS, END_FLAG, END_FLAG, END_FLAG, 8'h00,
                 END_FLAG, ERROR_FLAG, 8'h00, 8'hFF, END_FLAG, 8'h55,
                 VALUE_FLAG, 8'hFF, 8'hFF, 8'h01, 8'hFF, PHASE_FLAG, PHASE_FLAG,
                 END_FLAG, 8'h00,
                 HDR_TREND, END_FLAG, 8'h00, HDR_ALARM, 8'h12, END_FLAG, 8'h00};
    foreach (directed[i]) send_byte(directed[i]);

    set_curve_count(2'd1);
    tx_idle_pct = 33;
    rx_idle_pct = 63;
    hold_req = 1'b1;
    random_traffic(340);

    set_curve_count(2'd2);
    tx_idle_pct = 63;
    rx_idle_pct = 33;
    random_traffic(340);

    set_curve_count(2'd0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_traffic(120);

    set_curve_count(2'd3);
    random_traffic(220);

    wait_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== ventilator_serial_record_deframer_top.f =====
src/vsrd_pkg.sv
src/vsrd_if.sv
src/ventilator_serial_record_deframer_top.sv
tb/ventilator_serial_record_deframer_top_tb.sv
